// ===== src/lruk_pkg.sv =====
package lruk_pkg;

	localparam int FRAME_COUNT = 64;
	localparam int K_MAX = 8;
	localparam int FRAME_W = 6;
	localparam int KIDX_W = 3;
	localparam int TALLY_W = 4;
	localparam int STAMP_W = 48;
	localparam int COUNT_W = 7;
	localparam int HIST_DEPTH = FRAME_COUNT * K_MAX;
	localparam int HADDR_W = FRAME_W + KIDX_W;

	typedef enum logic [1:0] {
		CMD_ACCESS = 2'd0,
		CMD_SET_EVICT = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_EVICT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NONE = 2'd1,
		ST_REFUSED = 2'd2
	} status_t;

	localparam logic [3:0] HISTORY_K_RESET = 4'd2;

endpackage

// ===== src/lru_k_frame_replacer.sv =====
// set evictable and remove go straight to the result; access does an eight-entry history shift
// through the stamp memory, then writes the head stamp; evict does a 64-frame scan through a
// three-stage read pipeline, one frame a cycle
// one command at a time: busy stays high until the result, the next command can be taken at
// the edge that takes the result; the result strobe lasts one cycle, the receiver cannot stall
// arst_n clears flags, clock and count and sets k to 2 at once; stamp and tally memories are never cleared
module lru_k_frame_replacer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  cmd,
	input  logic [5:0]                  frame,
	input  logic                        make_evictable,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [3:0]                  cfg_data,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [5:0]                  victim,
	output logic [6:0]                  evictable_count
);
	import lruk_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_SHIFT, S_HEAD, S_SCAN, S_FINISH, S_RESULT
	} state_t;

	state_t state_q;
	logic [FRAME_COUNT-1:0] tracked_q;
	logic [FRAME_COUNT-1:0] evict_q;
	logic [STAMP_W-1:0] now_q;
	logic [COUNT_W-1:0] total_q;
	logic [3:0] hist_k_q;
	logic [3:0] keff_q;

	logic [STAMP_W-1:0] hist_mem [HIST_DEPTH];
	logic [STAMP_W-1:0] hist_rd;
	logic [HADDR_W-1:0] hist_rd_addr;
	logic hist_rd_en;
	logic [HADDR_W-1:0] hist_wr_addr;
	logic [STAMP_W-1:0] hist_wr_data;
	logic hist_wr_en;

	logic [TALLY_W-1:0] tally_mem [FRAME_COUNT];
	logic [TALLY_W-1:0] tally_rd;
	logic [FRAME_W-1:0] tally_rd_addr;
	logic tally_rd_en;
	logic [TALLY_W-1:0] tally_wr_data;
	logic tally_wr_en;

	logic [FRAME_W-1:0] frame_q;
	logic [KIDX_W-1:0] idx_q;
	logic wr_s1;
	logic [KIDX_W-1:0] widx_s1;
	logic [FRAME_W:0] scan_q;
	logic v_s1;
	logic [FRAME_W-1:0] f_s1;
	logic v_s2;
	logic cls_s2;
	logic [FRAME_W-1:0] f_s2;
	logic found_q;
	logic best_cls_q;
	logic [STAMP_W-1:0] best_key_q;
	logic [FRAME_W-1:0] best_q;

	always_ff @(posedge clk) begin
		if (hist_wr_en) hist_mem[hist_wr_addr] <= hist_wr_data;
		if (hist_rd_en) hist_rd <= hist_mem[hist_rd_addr];
	end

	// tally of an untracked frame is stale and never used
	always_ff @(posedge clk) begin
		if (tally_wr_en) tally_mem[frame_q] <= tally_wr_data;
		if (tally_rd_en) tally_rd <= tally_mem[tally_rd_addr];
	end

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;

	// second scan stage: class and key index from the tally just read
	logic s1_live;
	logic s1_cls;
	logic [KIDX_W-1:0] s1_kidx;
	always_comb begin
		s1_live = v_s1 && tracked_q[f_s1] && evict_q[f_s1];
		s1_cls = (tally_rd >= keff_q);
		s1_kidx = s1_cls ? KIDX_W'(keff_q - 4'd1) : KIDX_W'(tally_rd - 4'd1);
	end

	logic [STAMP_W-1:0] stamp_now;
	always_comb stamp_now = (now_q == '1) ? now_q : now_q + STAMP_W'(1);

	always_comb begin
		hist_rd_en = 1'b0;
		hist_rd_addr = {f_s1, s1_kidx};
		hist_wr_en = 1'b0;
		hist_wr_addr = {frame_q, widx_s1};
		hist_wr_data = hist_rd;
		tally_rd_en = 1'b0;
		tally_rd_addr = scan_q[FRAME_W-1:0];
		tally_wr_en = 1'b0;
		if (!tracked_q[frame_q]) tally_wr_data = TALLY_W'(1);
		else if (tally_rd < TALLY_W'(K_MAX)) tally_wr_data = tally_rd + TALLY_W'(1);
		else tally_wr_data = tally_rd;
		unique case (state_q)
			S_IDLE: begin
				tally_rd_en = start;
				tally_rd_addr = frame;
			end
			S_SHIFT: begin
				// read entry idx-1 now, it lands in entry idx next cycle
				hist_rd_en = (idx_q != '0);
				hist_rd_addr = {frame_q, idx_q - KIDX_W'(1)};
				hist_wr_en = wr_s1;
			end
			S_HEAD: begin
				hist_wr_en = 1'b1;
				hist_wr_addr = {frame_q, KIDX_W'(0)};
				hist_wr_data = stamp_now;
				tally_wr_en = 1'b1;
			end
			S_SCAN: begin
				tally_rd_en = !scan_q[FRAME_W];
				hist_rd_en = s1_live;
			end
			default: begin
			end
		endcase
	end

	logic better;
	always_comb begin
		better = !found_q || (cls_s2 < best_cls_q) ||
			(cls_s2 == best_cls_q && hist_rd < best_key_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tracked_q <= '0;
			evict_q <= '0;
			now_q <= '0;
			total_q <= '0;
			hist_k_q <= HISTORY_K_RESET;
			keff_q <= '0;
			done <= 1'b0;
			status <= ST_OK;
			victim <= '0;
			evictable_count <= '0;
			frame_q <= '0;
			idx_q <= '0;
			wr_s1 <= 1'b0;
			widx_s1 <= '0;
			scan_q <= '0;
			v_s1 <= 1'b0;
			f_s1 <= '0;
			v_s2 <= 1'b0;
			cls_s2 <= 1'b0;
			f_s2 <= '0;
			found_q <= 1'b0;
			best_cls_q <= 1'b0;
			best_key_q <= '0;
			best_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) hist_k_q <= cfg_data;
					if (start) begin
						frame_q <= frame;
						status <= ST_OK;
						victim <= '0;
						unique case (cmd_t'(cmd))
							CMD_ACCESS: begin
								idx_q <= KIDX_W'(K_MAX - 1);
								wr_s1 <= 1'b0;
								state_q <= S_SHIFT;
							end
							CMD_SET_EVICT: begin
								if (tracked_q[frame]) begin
									if (evict_q[frame] && !make_evictable) begin
										evict_q[frame] <= 1'b0;
										if (total_q != '0) total_q <= total_q - 7'd1;
									end else if (!evict_q[frame] && make_evictable) begin
										evict_q[frame] <= 1'b1;
										total_q <= total_q + 7'd1;
									end
								end
								state_q <= S_RESULT;
							end
							CMD_REMOVE: begin
								if (tracked_q[frame]) begin
									if (!evict_q[frame]) status <= ST_REFUSED;
									else begin
										tracked_q[frame] <= 1'b0;
										evict_q[frame] <= 1'b0;
										if (total_q != '0) total_q <= total_q - 7'd1;
									end
								end
								state_q <= S_RESULT;
							end
							CMD_EVICT: begin
								keff_q <= (hist_k_q == '0) ? 4'd1 :
									(hist_k_q > 4'(K_MAX)) ? 4'(K_MAX) : hist_k_q;
								scan_q <= '0;
								v_s1 <= 1'b0;
								v_s2 <= 1'b0;
								found_q <= 1'b0;
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SHIFT: begin
					wr_s1 <= (idx_q != '0);
					widx_s1 <= idx_q;
					if (idx_q == '0) state_q <= S_HEAD;
					else idx_q <= idx_q - KIDX_W'(1);
				end
				S_HEAD: begin
					// an untracked frame already has its evictable flag clear
					now_q <= stamp_now;
					tracked_q[frame_q] <= 1'b1;
					state_q <= S_RESULT;
				end
				S_SCAN: begin
					v_s1 <= !scan_q[FRAME_W];
					f_s1 <= scan_q[FRAME_W-1:0];
					v_s2 <= s1_live;
					cls_s2 <= s1_cls;
					f_s2 <= f_s1;
					// strict compare keeps the lower frame on equal keys
					if (v_s2 && better) begin
						found_q <= 1'b1;
						best_cls_q <= cls_s2;
						best_key_q <= hist_rd;
						best_q <= f_s2;
					end
					if (scan_q == (FRAME_W+1)'(FRAME_COUNT + 1)) state_q <= S_FINISH;
					else scan_q <= scan_q + (FRAME_W+1)'(1);
				end
				S_FINISH: begin
					if (found_q) begin
						tracked_q[best_q] <= 1'b0;
						evict_q[best_q] <= 1'b0;
						if (total_q != '0) total_q <= total_q - 7'd1;
						victim <= best_q;
					end else begin
						status <= ST_NONE;
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					done <= 1'b1;
					evictable_count <= total_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_RESULT)
		else $error("done without result state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command not taken");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != ST_NONE || victim == '0))
		else $error("failed evict names a victim");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> !busy)
		else $error("config written while busy");

endmodule

// ===== tb/lru_k_frame_replacer_chk.sv =====
`timescale 1ns / 1ps
module lru_k_frame_replacer_chk (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         busy,
	input  logic [1:0]   cmd,
	input  logic [5:0]   frame,
	input  logic         make_evictable,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [3:0]   cfg_data,
	input  logic         done,
	input  logic [1:0]   status,
	input  logic [5:0]   victim,
	input  logic [6:0]   evictable_count,
	output int           fail_count,
	output int           pending
);
	import lruk_pkg::*;

	typedef struct packed {
		status_t              st;
		logic [FRAME_W-1:0]   vic;
		logic [COUNT_W-1:0]   cnt;
	} outcome_t;

	localparam logic [STAMP_W-1:0] STAMP_TOP = {STAMP_W{1'b1}};

	logic [3:0]           k_reg;
	logic                 in_use [FRAME_COUNT];
	logic                 evictable [FRAME_COUNT];
	logic [TALLY_W-1:0]   hits [FRAME_COUNT];
	logic [STAMP_W-1:0]   stamps [FRAME_COUNT][K_MAX];
	logic [STAMP_W-1:0]   clock_now;
	logic [COUNT_W-1:0]   n_evictable;
	outcome_t             outcome_q [$];

	function automatic outcome_t replace_step(cmd_t c, int f, logic mk);
		outcome_t o;
		int k;
		bit found;
		int best;
		bit best_cls;
		logic [STAMP_W-1:0] best_key;
		bit cls;
		logic [STAMP_W-1:0] key;
		o.st = ST_OK;
		o.vic = '0;
		case (c)
			CMD_EVICT: begin
				k = (k_reg == 0) ? 1 : (k_reg > K_MAX ? K_MAX : int'(k_reg));
				found = 0;
				best = 0;
				best_cls = 0;
				best_key = '0;
				for (int i = 0; i < FRAME_COUNT; i++) begin
					if (!in_use[i] || !evictable[i])
						continue;
					// young frames rank by first access, the rest by k-th latest stamp
					if (hits[i] < k) begin
						cls = 0;
						key = stamps[i][hits[i]-1];
					end else begin
						cls = 1;
						key = stamps[i][k-1];
					end
					if (!found || cls < best_cls || (cls == best_cls && key < best_key)) begin
						found = 1;
						best = i;
						best_cls = cls;
						best_key = key;
					end
				end
				if (found) begin
					in_use[best] = 0;
					evictable[best] = 0;
					hits[best] = 0;
					if (n_evictable > 0)
						n_evictable--;
					o.vic = best[FRAME_W-1:0];
				end else begin
					o.st = ST_NONE;
				end
			end
			CMD_ACCESS: begin
				if (clock_now != STAMP_TOP)
					clock_now++;
				if (!in_use[f]) begin
					in_use[f] = 1;
					evictable[f] = 0;
					hits[f] = 0;
				end
				for (int i = K_MAX - 1; i > 0; i--)
					stamps[f][i] = stamps[f][i-1];
				stamps[f][0] = clock_now;
				if (hits[f] < K_MAX)
					hits[f]++;
			end
			CMD_SET_EVICT: begin
				if (in_use[f]) begin
					if (evictable[f] && !mk) begin
						evictable[f] = 0;
						if (n_evictable > 0)
							n_evictable--;
					end else if (!evictable[f] && mk) begin
						evictable[f] = 1;
						n_evictable++;
					end
				end
			end
			default: begin
				if (in_use[f]) begin
					if (!evictable[f]) begin
						o.st = ST_REFUSED;
					end else begin
						in_use[f] = 0;
						evictable[f] = 0;
						hits[f] = 0;
						if (n_evictable > 0)
							n_evictable--;
					end
				end
			end
		endcase
		o.cnt = n_evictable;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			k_reg = HISTORY_K_RESET;
			for (int i = 0; i < FRAME_COUNT; i++) begin
				in_use[i] = 0;
				evictable[i] = 0;
				hits[i] = 0;
			end
			clock_now = '0;
			n_evictable = '0;
			outcome_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: status %0d victim %0d count %0d",
							status, victim, evictable_count);
				end else begin
					e = outcome_q.pop_front();
					if (status !== e.st || victim !== e.vic || evictable_count !== e.cnt) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
								e.st, e.vic, e.cnt, status, victim, evictable_count);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				k_reg = cfg_data;
			if (start && !busy)
				outcome_q = {outcome_q,
					replace_step(cmd_t'(cmd), int'(frame), make_evictable)};
			pending = outcome_q.size();
		end
	end

endmodule

// ===== tb/lru_k_frame_replacer_tb.sv =====
`timescale 1ns / 1ps
module lru_k_frame_replacer_tb;
	import lruk_pkg::*;

	localparam int WATCHDOG = 20000;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         start = 0;
	logic         busy;
	logic [1:0]   cmd = '0;
	logic [5:0]   frame = '0;
	logic         make_evictable = 0;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [3:0]   cfg_data = '0;
	logic         done;
	logic [1:0]   status;
	logic [5:0]   victim;
	logic [6:0]   evictable_count;
	int           fail_count;
	int           pending;
	int           quiet_cycles = 0;

	always #1 clk = ~clk;

	lru_k_frame_replacer dut (.*);

	lru_k_frame_replacer_chk chk (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	int gap_left = 0;
	int burst_left = 0;

	task automatic issue(cmd_t c, int f, logic mk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
		end
		repeat (gap_left) @(negedge clk);
		gap_left = 0;
		burst_left--;
		cmd = c;
		frame = f[5:0];
		make_evictable = mk;
		start = 1;
		do @(posedge clk); while (!(start && !busy));
		@(negedge clk);
		start = 0;
	endtask

	task automatic write_k(logic [3:0] k);
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		cfg_data = k;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// mostly a small hot set so frames gather histories and evictions compete
	task automatic random_phase(int n);
		int f;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			f = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
			if (r < 45)
				issue(CMD_ACCESS, f, 1'($urandom_range(0, 1)));
			else if (r < 72)
				issue(CMD_SET_EVICT, f, ($urandom_range(0, 3) != 0));
			else if (r < 82)
				issue(CMD_REMOVE, f, 1'($urandom_range(0, 1)));
			else
				issue(CMD_EVICT, $urandom_range(0, 63), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: empty evict, extremes, refused remove, untracked frames
		issue(CMD_EVICT, 0, 0);
		issue(CMD_SET_EVICT, 63, 1);
		issue(CMD_REMOVE, 63, 1);
		issue(CMD_ACCESS, 0, 0);
		issue(CMD_ACCESS, 63, 1);
		issue(CMD_REMOVE, 0, 0);
		issue(CMD_SET_EVICT, 0, 1);
		issue(CMD_SET_EVICT, 63, 1);
		issue(CMD_SET_EVICT, 63, 1);
		issue(CMD_ACCESS, 63, 0);
		issue(CMD_ACCESS, 63, 0);
		issue(CMD_ACCESS, 0, 0);
		issue(CMD_EVICT, 42, 1);
		issue(CMD_EVICT, 21, 0);
		issue(CMD_EVICT, 63, 1);
		issue(CMD_ACCESS, 5, 0);
		issue(CMD_SET_EVICT, 5, 1);
		issue(CMD_SET_EVICT, 5, 0);
		issue(CMD_REMOVE, 5, 0);
		issue(CMD_SET_EVICT, 5, 1);
		issue(CMD_REMOVE, 5, 0);
		for (int i = 0; i < 12; i++) begin
			write_k(i[3:0] == 9 ? 4'd15 : (i[3:0] == 10 ? 4'd0 : i[3:0]));
			random_phase(150);
		end
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== lru_k_frame_replacer.f =====
src/lruk_pkg.sv
src/lru_k_frame_replacer.sv
tb/lru_k_frame_replacer_chk.sv
tb/lru_k_frame_replacer_tb.sv
